>>> hdl/sofl_pkg.sv
package sofl_pkg;

    localparam int SLAB_SLOTS_DEF = 256;

    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 9;
    localparam int OFFSET_W = 20;
    localparam int STATUS_W = 2;
    localparam int SSTATE_W = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT_COUNT = 2'd1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_OFFSET   = 2'd3;

    localparam logic [SSTATE_W-1:0] SLAB_EMPTY   = 2'd0;
    localparam logic [SSTATE_W-1:0] SLAB_PARTIAL = 2'd1;
    localparam logic [SSTATE_W-1:0] SLAB_FULL    = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_WALK,
        S_ALLOC,
        S_PUSH,
        S_RESP
    } fsm_state_t;

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] dividend;
        logic [SIZE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hdl/slab_object_free_list_core.sv
// Free-list manager for one slab. Each input transfer is an allocate or a free of a byte
// offset; each one produces exactly one result transfer with status, allocated offset, slab
// state and in-use count. The links live in a single synchronous RAM of SLAB_SLOTS entries.
// One item is in flight at a time: an allocate passes through S_ALLOC to S_RESP (directly
// to S_RESP when the slab is full); a free with a zero object size goes directly to S_RESP,
// and any other free first runs the 20-step offset divider in S_DIV. An out-of-range index
// then goes to S_RESP; otherwise S_WALK follows the free list from the head and answers a
// double free where it meets the index, or else moves on to S_PUSH, which puts the object
// back at the head. A result that is not taken holds the block in S_RESP. After reset, and
// after every write of object_count, the RAM is rebuilt by a pass over all SLAB_SLOTS
// entries during which s_tready is low; configuration writes are taken at any time but are
// meant only for an idle block.
module slab_object_free_list_core
    import sofl_pkg::*;
#(
    parameter int SLAB_SLOTS = SLAB_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,  // byte_offset[19:0], zero pad
    input  logic [0:0]             s_tuser,  // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[1:0], alloc_offset[21:2], slab_state[23:22], used_count[32:24], zero pad
    output logic [39:0]            m_tdata
);

    localparam int IDXW      = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
    localparam int LINKW     = $clog2(SLAB_SLOTS + 1);
    localparam int MULW      = (LINKW + SIZE_W > OFFSET_W) ? LINKW + SIZE_W : OFFSET_W;
    localparam int COUNT_TOP = (1 << COUNT_W) - 1;
    localparam int CNT_CLAMP = (SLAB_SLOTS > COUNT_TOP) ? COUNT_TOP : SLAB_SLOTS;
    localparam int OUT_USED  = STATUS_W + OFFSET_W + SSTATE_W + COUNT_W;

    fsm_state_t state_reg, state_next;

    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LINKW-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]  inuse_reg, inuse_next;
    logic [IDXW-1:0]     sweep_reg, sweep_next;
    logic [IDXW-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic                first_reg, first_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OFFSET_W-1:0] aoff_reg, aoff_next;
    logic                m_valid_reg, m_valid_next;
    logic [39:0]         m_data_reg, m_data_next;

    logic [COUNT_W-1:0]  eff_cnt;
    logic [COUNT_W-1:0]  cnt_nz;
    logic                full;
    logic                s_accept;
    logic                cfg_accept;
    logic                cnt_write;
    logic                out_free;
    logic                sweep_last;
    logic [LINKW-1:0]    cur;
    logic [MULW-1:0]     prod;
    logic [SSTATE_W-1:0] slab_state;

    logic             ram_we;
    logic [IDXW-1:0]  ram_waddr;
    logic [LINKW-1:0] ram_wdata;
    logic [IDXW-1:0]  ram_raddr;
    logic [LINKW-1:0] ram_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sofl_ram #(
        .WIDTH (LINKW),
        .DEPTH (SLAB_SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sofl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cnt_write  = cfg_accept && (cfg_index == CFG_OBJECT_COUNT);
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign sweep_last = (sweep_reg == IDXW'(SLAB_SLOTS - 1));

    assign cnt_nz  = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign eff_cnt = (cnt_nz > COUNT_W'(CNT_CLAMP)) ? COUNT_W'(CNT_CLAMP) : cnt_nz;
    assign full    = (inuse_reg >= eff_cnt);

    // walk starts at the head register, then follows the link just read
    assign cur  = first_reg ? head_reg : ram_rdata;
    assign prod = MULW'(head_reg) * MULW'(size_reg);

    always_comb begin
        if (inuse_reg == '0) begin
            slab_state = SLAB_EMPTY;
        end else if (full) begin
            slab_state = SLAB_FULL;
        end else begin
            slab_state = SLAB_PARTIAL;
        end
    end

    assign div_req.start    = s_accept && (s_tuser[0] == OP_FREE) && (size_reg != '0);
    assign div_req.dividend = s_tdata[OFFSET_W-1:0];
    assign div_req.divisor  = size_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP: begin
                if (sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == OP_ALLOC) begin
                        state_next = full ? S_RESP : S_ALLOC;
                    end else begin
                        state_next = (size_reg == '0) ? S_RESP : S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = (div_rsp.quotient >= OFFSET_W'(eff_cnt)) ? S_RESP : S_WALK;
                end
            end
            S_WALK: begin
                if (rem_reg == '0) begin
                    state_next = S_PUSH;
                end else if (cur == LINKW'(idx_reg)) begin
                    state_next = S_RESP;
                end
            end
            S_ALLOC: state_next = S_RESP;
            S_PUSH:  state_next = S_RESP;
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_SWEEP;
        endcase
        if (cnt_write) state_next = S_SWEEP;
    end

    // datapath and memory control
    always_comb begin
        size_next    = size_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        inuse_next   = inuse_reg;
        sweep_next   = sweep_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        first_next   = first_reg;
        status_next  = status_reg;
        aoff_next    = aoff_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = sweep_reg;
        ram_wdata    = LINKW'(sweep_reg) + 1'b1;
        ram_raddr    = head_reg[IDXW-1:0];
        case (state_reg)
            S_SWEEP: begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_accept) begin
                    aoff_next = '0;
                    if (s_tuser[0] == OP_ALLOC) begin
                        status_next = full ? STAT_NONE_FREE : STAT_OK;
                    end else begin
                        status_next = (size_reg == '0) ? STAT_BAD_OFFSET : STAT_OK;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient >= OFFSET_W'(eff_cnt)) begin
                        status_next = STAT_BAD_OFFSET;
                    end
                    idx_next   = div_rsp.quotient[IDXW-1:0];
                    rem_next   = eff_cnt - inuse_reg;
                    first_next = 1'b1;
                end
            end
            S_WALK: begin
                if (rem_reg != '0) begin
                    if (cur == LINKW'(idx_reg)) begin
                        status_next = STAT_ALREADY_FREE;
                    end else begin
                        ram_raddr  = cur[IDXW-1:0];
                        rem_next   = rem_reg - 1'b1;
                        first_next = 1'b0;
                    end
                end
            end
            S_ALLOC: begin
                head_next  = ram_rdata;
                inuse_next = inuse_reg + 1'b1;
                aoff_next  = prod[OFFSET_W-1:0];
            end
            S_PUSH: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = head_reg;
                head_next  = LINKW'(idx_reg);
                inuse_next = inuse_reg - 1'b1;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(40 - OUT_USED)'(0), inuse_reg, slab_state,
                                    aoff_reg, status_reg};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        if (cfg_accept && (cfg_index == CFG_OBJECT_SIZE)) begin
            size_next = cfg_data[SIZE_W-1:0];
        end
        if (cnt_write) begin
            count_next = cfg_data[COUNT_W-1:0];
            head_next  = '0;
            inuse_next = '0;
            sweep_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            size_reg    <= SIZE_RESET;
            count_reg   <= COUNT_RESET;
            head_reg    <= '0;
            inuse_reg   <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            inuse_reg   <= inuse_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        aoff_reg   <= aoff_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_inuse_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        inuse_reg <= eff_cnt)
        else $error("in-use count above slab size");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in flight");

    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SWEEP || state_reg == S_PUSH))
        else $error("link ram written outside rebuild or push");

    a_empty_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[32:24] == '0) |-> (m_tdata[23:22] == SLAB_EMPTY))
        else $error("slab state disagrees with used count");

endmodule

>>> hdl/sofl_ram.sv
module sofl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sofl_div.sv
module sofl_div
    import sofl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(OFFSET_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   dvs_reg, dvs_next;
    logic [OFFSET_W-1:0] dq_reg, dq_next;
    logic [SIZE_W:0]     trial;
    logic                qbit;

    // one quotient bit per cycle, restoring
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        trial     = {rem_reg, dq_reg[OFFSET_W-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(OFFSET_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            dq_next   = req.dividend;
        end else if (busy_reg) begin
            if (qbit) begin
                rem_next = SIZE_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[SIZE_W-1:0];
            end
            dq_next  = {dq_reg[OFFSET_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule
